// File: hw/rtl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg
// Types, constants and key tables shared by the form command parser.
// ----------------------------------------------------------------------------
package fcp_pkg;

  localparam int FCP_MAX_PAYLOAD     = 256;
  localparam int FCP_MAX_VALUE_CHARS = 11;

  localparam int          ACC_W        = 17;
  localparam logic [16:0] ACC_MAX      = 17'h1FFFF;
  localparam logic [16:0] OUTLET_MAX   = 17'h000FF;
  localparam logic [16:0] DURATION_MAX = 17'h0FFFF;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic KEY_OUTLET   = 1'b0;
  localparam logic KEY_DURATION = 1'b1;

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_TOO_LONG       = 4'd1,
    ERR_SEP_COUNT      = 4'd2,
    ERR_KEY_MISSING    = 4'd3,
    ERR_NO_EQUALS      = 4'd4,
    ERR_OUTLET_LONG    = 4'd5,
    ERR_DURATION_LONG  = 4'd6,
    ERR_OUTLET_RANGE   = 4'd7,
    ERR_DURATION_RANGE = 4'd8
  } fcp_err_t;

  typedef enum logic [1:0] {
    PH_SIGN    = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } fcp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_item;
    logic       end_only;
  } fcp_cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  error_code;
    logic [7:0]  outlet_number;
    logic [15:0] run_seconds;
  } fcp_result_t;

  typedef struct packed {
    logic       char_en;
    logic       msg_end;
    logic [7:0] ch;
  } fcp_step_t;

  typedef struct packed {
    logic             found;
    logic             place_err;
    logic             too_long;
    logic             negative;
    logic [ACC_W-1:0] accum;
  } fcp_key_status_t;

  function automatic logic [3:0] fcp_key_len(input logic sel);
    logic [3:0] len;
    len = (sel == KEY_OUTLET) ? 4'd8 : 4'd9;
    return len;
  endfunction

  // "pumpGpio" and "durationS"
  function automatic logic [7:0] fcp_key_char(input logic sel, input logic [3:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    if (sel == KEY_OUTLET) begin
      case (idx)
        4'd0: ch = "p";
        4'd1: ch = "u";
        4'd2: ch = "m";
        4'd3: ch = "p";
        4'd4: ch = "G";
        4'd5: ch = "p";
        4'd6: ch = "i";
        4'd7: ch = "o";
        default: ch = CH_NUL;
      endcase
    end else begin
      case (idx)
        4'd0: ch = "d";
        4'd1: ch = "u";
        4'd2: ch = "r";
        4'd3: ch = "a";
        4'd4: ch = "t";
        4'd5: ch = "i";
        4'd6: ch = "o";
        4'd7: ch = "n";
        4'd8: ch = "S";
        default: ch = CH_NUL;
      endcase
    end
    return ch;
  endfunction

  // Matched-prefix update with fallback on mismatch.
  // Outlet key: prefixes ending in 'p' (lengths 4 and 6) fall back to "pu" on 'u'.
  // Duration key has no repeated letters, so only 'd' restarts it.
  function automatic logic [3:0] fcp_advance(input logic sel, input logic [3:0] p,
                                             input logic [7:0] c);
    logic [3:0] n;
    if (c == fcp_key_char(sel, p)) begin
      n = p + 4'd1;
    end else if (sel == KEY_OUTLET) begin
      if (c == "u" && (p == 4'd4 || p == 4'd6)) begin
        n = 4'd2;
      end else if (c == "p") begin
        n = 4'd1;
      end else begin
        n = 4'd0;
      end
    end else begin
      n = (c == "d") ? 4'd1 : 4'd0;
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/fcp_cmd_if.sv
// ----------------------------------------------------------------------------
// fcp_cmd_if
// Command byte channel: valid/ready with one byte request per transfer.
// ----------------------------------------------------------------------------
interface fcp_cmd_if;
  import fcp_pkg::*;

  logic     valid;
  logic     ready;
  fcp_cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/fcp_result_if.sv
// ----------------------------------------------------------------------------
// fcp_result_if
// Parse result channel: valid/ready with one result request per message.
// ----------------------------------------------------------------------------
interface fcp_result_if;
  import fcp_pkg::*;

  logic        valid;
  logic        ready;
  fcp_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/fcp_key_match.sv
// ----------------------------------------------------------------------------
// fcp_key_match
// Finds the first occurrence of one key, checks the '=' after it and
// converts the value that follows as a signed decimal with saturation.
// ----------------------------------------------------------------------------
module fcp_key_match #(
  parameter logic KEY_SEL         = 1'b0,
  parameter int   MAX_VALUE_CHARS = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fcp_pkg::fcp_step_t       step,
  output fcp_pkg::fcp_key_status_t status
);
  import fcp_pkg::*;

  localparam int VLW = $clog2(MAX_VALUE_CHARS + 2);

  logic [3:0]       progress, progress_next;
  logic             found, found_next;
  logic             await_eq, await_eq_next;
  logic             bad, bad_next;
  logic             capt, capt_next;
  logic [VLW-1:0]   vlen, vlen_next;
  fcp_phase_t       phase, phase_next;
  logic             neg, neg_next;
  logic [ACC_W-1:0] accum, accum_next;

  logic [3:0]       adv;
  logic             is_digit;
  logic             is_blank;
  logic [ACC_W+3:0] acc_wide;
  logic [ACC_W+3:0] prod;

  always_comb begin
    adv      = fcp_advance(KEY_SEL, progress, step.ch);
    is_digit = (step.ch >= CH_ZERO) && (step.ch <= CH_NINE);
    is_blank = (step.ch == CH_VT) || (step.ch == CH_FF) || (step.ch == CH_CR);
    acc_wide = {4'b0, accum};
    prod     = (acc_wide << 3) + (acc_wide << 1) + {{(ACC_W){1'b0}}, step.ch[3:0]};

    progress_next = progress;
    found_next    = found;
    await_eq_next = await_eq;
    bad_next      = bad;
    capt_next     = capt;
    vlen_next     = vlen;
    phase_next    = phase;
    neg_next      = neg;
    accum_next    = accum;

    if (step.char_en) begin
      if (capt) begin
        if (step.ch == CH_AMP) begin
          capt_next = 1'b0;
        end else begin
          if (vlen <= VLW'(MAX_VALUE_CHARS)) begin
            vlen_next = vlen + VLW'(1);
          end
          case (phase)
            PH_SIGN: begin
              if (is_blank) begin
                phase_next = PH_SIGN;
              end else if (step.ch == CH_PLUS || step.ch == CH_MINUS) begin
                neg_next   = (step.ch == CH_MINUS);
                phase_next = PH_DIGITS;
              end else if (is_digit) begin
                accum_next = (prod > {4'b0, ACC_MAX}) ? ACC_MAX : prod[ACC_W-1:0];
                phase_next = PH_DIGITS;
              end else begin
                phase_next = PH_STOPPED;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                accum_next = (prod > {4'b0, ACC_MAX}) ? ACC_MAX : prod[ACC_W-1:0];
              end else begin
                phase_next = PH_STOPPED;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end else if (await_eq) begin
        await_eq_next = 1'b0;
        if (step.ch == CH_EQ) begin
          capt_next = 1'b1;
        end else begin
          bad_next = 1'b1;
        end
      end else if (!found) begin
        if (adv >= fcp_key_len(KEY_SEL)) begin
          found_next    = 1'b1;
          await_eq_next = 1'b1;
          progress_next = 4'd0;
        end else begin
          progress_next = adv;
        end
      end
    end

    status.found     = found_next;
    status.place_err = await_eq_next | bad_next;
    status.too_long  = vlen_next > VLW'(MAX_VALUE_CHARS);
    status.negative  = neg_next;
    status.accum     = accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst || step.msg_end) begin
      progress <= '0;
      found    <= 1'b0;
      await_eq <= 1'b0;
      bad      <= 1'b0;
      capt     <= 1'b0;
      vlen     <= '0;
      phase    <= PH_SIGN;
      neg      <= 1'b0;
      accum    <= '0;
    end else begin
      progress <= progress_next;
      found    <= found_next;
      await_eq <= await_eq_next;
      bad      <= bad_next;
      capt     <= capt_next;
      vlen     <= vlen_next;
      phase    <= phase_next;
      neg      <= neg_next;
      accum    <= accum_next;
    end
  end

endmodule

// File: hw/rtl/fcp_eval.sv
// ----------------------------------------------------------------------------
// fcp_eval
// End-of-message checks in priority order; builds the result request.
// ----------------------------------------------------------------------------
module fcp_eval (
  input  logic                     too_long,
  input  logic [1:0]               amp_count,
  input  logic [1:0]               eq_count,
  input  fcp_pkg::fcp_key_status_t outlet,
  input  fcp_pkg::fcp_key_status_t duration,
  output fcp_pkg::fcp_result_t     result
);
  import fcp_pkg::*;

  fcp_err_t err;

  always_comb begin
    if (too_long) begin
      err = ERR_TOO_LONG;
    end else if (amp_count != 2'd1 || eq_count != 2'd2) begin
      err = ERR_SEP_COUNT;
    end else if (!outlet.found || !duration.found) begin
      err = ERR_KEY_MISSING;
    end else if (outlet.place_err || duration.place_err) begin
      err = ERR_NO_EQUALS;
    end else if (outlet.too_long) begin
      err = ERR_OUTLET_LONG;
    end else if (duration.too_long) begin
      err = ERR_DURATION_LONG;
    end else if ((outlet.negative && outlet.accum != '0) || outlet.accum > OUTLET_MAX) begin
      err = ERR_OUTLET_RANGE;
    end else if (duration.negative || duration.accum == '0
                 || duration.accum > DURATION_MAX) begin
      err = ERR_DURATION_RANGE;
    end else begin
      err = ERR_NONE;
    end

    result.accepted      = (err == ERR_NONE);
    result.error_code    = err;
    result.outlet_number = (err == ERR_NONE) ? outlet.accum[7:0] : 8'd0;
    result.run_seconds   = (err == ERR_NONE) ? duration.accum[15:0] : 16'd0;
  end

endmodule

// File: hw/rtl/form_command_parser.sv
// ----------------------------------------------------------------------------
// form_command_parser
// Streaming parser for a form-encoded outlet/duration command.
// ----------------------------------------------------------------------------
// The block takes one command byte per cycle unless a final item stalls, and gives
// one result per message. A byte is first held in the input register, then updates
// the separator counters and both key matchers; on the final item (or an
// end-only item) the checks run on that updated state and the result is
// loaded into the output register as that item leaves the input register.
// While a result waits to be taken, bytes keep flowing; only a
// further final item waits in the input register until the output frees up.
// All message state returns to zero when the result is formed.
module form_command_parser #(
  parameter int MAX_PAYLOAD     = fcp_pkg::FCP_MAX_PAYLOAD,
  parameter int MAX_VALUE_CHARS = fcp_pkg::FCP_MAX_VALUE_CHARS
) (
  input  logic         clk,
  input  logic         rst,
  fcp_cmd_if.sink      cmd,
  fcp_result_if.source result
);
  import fcp_pkg::*;

  localparam int RLW = $clog2(MAX_PAYLOAD + 2);

  logic            s1_valid;
  fcp_cmd_t        s1_item;
  logic            s1_end;
  logic            stall;
  logic            go;

  logic [RLW-1:0]  raw_length, raw_length_next;
  logic [1:0]      amp_count, amp_count_next;
  logic [1:0]      eq_count, eq_count_next;
  logic            nul_seen, nul_seen_next;

  logic            byte_seen;
  logic            ch_ok;
  fcp_step_t       step;
  fcp_key_status_t outlet_status;
  fcp_key_status_t duration_status;
  fcp_result_t     res_next;

  logic            out_valid;
  fcp_result_t     out_payload;

  assign s1_end    = s1_item.final_item | s1_item.end_only;
  assign stall     = s1_valid && s1_end && out_valid && !result.ready;
  assign go        = s1_valid && !stall;
  assign cmd.ready = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_item <= cmd.payload;
    end
  end

  always_comb begin
    byte_seen = go && !s1_item.end_only;
    ch_ok     = byte_seen && s1_item.data_byte != CH_SPACE
                && s1_item.data_byte != CH_TAB && s1_item.data_byte != CH_LF;

    raw_length_next = raw_length;
    if (byte_seen && raw_length <= RLW'(MAX_PAYLOAD)) begin
      raw_length_next = raw_length + RLW'(1);
    end

    amp_count_next = amp_count;
    eq_count_next  = eq_count;
    if (ch_ok && s1_item.data_byte == CH_AMP && amp_count != 2'd3) begin
      amp_count_next = amp_count + 2'd1;
    end
    if (ch_ok && s1_item.data_byte == CH_EQ && eq_count != 2'd3) begin
      eq_count_next = eq_count + 2'd1;
    end

    nul_seen_next = nul_seen | (ch_ok && s1_item.data_byte == CH_NUL);

    step.char_en = ch_ok && s1_item.data_byte != CH_NUL && !nul_seen;
    step.msg_end = go && s1_end;
    step.ch      = s1_item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || step.msg_end) begin
      raw_length <= '0;
      amp_count  <= 2'd0;
      eq_count   <= 2'd0;
      nul_seen   <= 1'b0;
    end else begin
      raw_length <= raw_length_next;
      amp_count  <= amp_count_next;
      eq_count   <= eq_count_next;
      nul_seen   <= nul_seen_next;
    end
  end

  fcp_key_match #(
    .KEY_SEL         (KEY_OUTLET),
    .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
  ) u_outlet (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .status (outlet_status)
  );

  fcp_key_match #(
    .KEY_SEL         (KEY_DURATION),
    .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
  ) u_duration (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .status (duration_status)
  );

  fcp_eval u_eval (
    .too_long  (raw_length_next > RLW'(MAX_PAYLOAD)),
    .amp_count (amp_count_next),
    .eq_count  (eq_count_next),
    .outlet    (outlet_status),
    .duration  (duration_status),
    .result    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.msg_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.msg_end) begin
      out_payload <= res_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_payload;

endmodule

// File: hw/rtl/fcp_checker.sv
// ----------------------------------------------------------------------------
// fcp_checker
// Port-level checks on the parser result channel, bound to the top level.
// ----------------------------------------------------------------------------
module fcp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input fcp_pkg::fcp_result_t res_payload
);
  import fcp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("result request dropped or changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_payload.accepted == (res_payload.error_code == ERR_NONE))
    else $error("accepted flag disagrees with error code");

  a_dur: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_payload.accepted |-> res_payload.run_seconds != 16'd0)
    else $error("accepted result with zero duration");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_payload.accepted |->
      res_payload.outlet_number == 8'd0 && res_payload.run_seconds == 16'd0)
    else $error("rejected result carries values");

  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind form_command_parser fcp_checker u_fcp_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_payload (result.payload)
);

// File: bench/form_command_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// form_command_parser_test
// Drives form-encoded outlet/duration commands into the parser one byte
// request at a time. A local model of the parser predicts every result at
// message end, and each returned result is checked field by field. Directed
// commands cover each error code, sign and blank handling, zero bytes, key
// placement and the payload length limit. Random commands follow under three
// idle patterns, most well formed with random values, the rest broken or noise.
// ----------------------------------------------------------------------------
module form_command_parser_test;
  import fcp_pkg::*;

  localparam logic [3:0] FLAG_FOUND = 4'b0001;
  localparam logic [3:0] FLAG_AWAIT = 4'b0010;
  localparam logic [3:0] FLAG_BAD   = 4'b0100;
  localparam logic [3:0] FLAG_CAPT  = 4'b1000;

  localparam int STYLE_FINAL_BYTE = 0;
  localparam int STYLE_END_ONLY   = 1;
  localparam int STYLE_FINAL_BOTH = 2;

  logic clk;
  logic rst;

  fcp_cmd_if    cmd ();
  fcp_result_if result ();

  form_command_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .result (result)
  );

  string key_name [2] = '{"pumpGpio", "durationS"};
  string decoys [7] = '{"pump", "pumpGp", "pumpGpu", "pupumpG", "dura", "ddurat", "pumpGpi"};

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;

  fcp_result_t parse_results_q[$];
  logic [7:0]  msg_bytes[$];

  // parser model state
  int unsigned raw_len;
  int unsigned amp_cnt;
  int unsigned eq_cnt;
  int unsigned key_pos [2];
  logic [3:0]  key_state [2];
  int unsigned val_len [2];
  fcp_phase_t  val_phase [2];
  logic        val_neg [2];
  logic [16:0] val_acc [2];
  logic        nul_hit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_parse_state();
    raw_len = 0;
    amp_cnt = 0;
    eq_cnt  = 0;
    nul_hit = 1'b0;
    for (int s = 0; s < 2; s++) begin
      key_pos[s]   = 0;
      key_state[s] = '0;
      val_len[s]   = 0;
      val_phase[s] = PH_SIGN;
      val_neg[s]   = 1'b0;
      val_acc[s]   = '0;
    end
  endfunction

  function automatic int unsigned next_match(int s, int unsigned p, logic [7:0] c);
    bit ok;
    if (key_name[s][p] == c) return p + 1;
    for (int unsigned n = p; n >= 1; n--) begin
      ok = (key_name[s][n-1] == c);
      for (int unsigned j = 0; ok && j + 1 < n; j++) begin
        if (key_name[s][j] != key_name[s][p-n+1+j]) ok = 1'b0;
      end
      if (ok) return n;
    end
    return 0;
  endfunction

  function automatic void take_value_char(int s, logic [7:0] c);
    logic [31:0] grown;
    if (val_len[s] <= FCP_MAX_VALUE_CHARS) val_len[s]++;
    if (val_phase[s] == PH_SIGN) begin
      if (c == CH_VT || c == CH_FF || c == CH_CR) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        val_neg[s]   = (c == CH_MINUS);
        val_phase[s] = PH_DIGITS;
        return;
      end
      val_phase[s] = PH_DIGITS;
    end
    if (val_phase[s] == PH_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        grown = 32'(val_acc[s]) * 32'd10 + 32'(c - CH_ZERO);
        val_acc[s] = (grown > 32'(ACC_MAX)) ? ACC_MAX : grown[16:0];
      end else begin
        val_phase[s] = PH_STOPPED;
      end
    end
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [3:0]  f;
    int unsigned p;
    for (int s = 0; s < 2; s++) begin
      f = key_state[s];
      if (f & FLAG_CAPT) begin
        if (c == CH_AMP) key_state[s] = f & ~FLAG_CAPT;
        else take_value_char(s, c);
      end else if (f & FLAG_AWAIT) begin
        f = f & ~FLAG_AWAIT;
        f = f | ((c == CH_EQ) ? FLAG_CAPT : FLAG_BAD);
        key_state[s] = f;
      end else if (!(f & FLAG_FOUND)) begin
        p = next_match(s, key_pos[s], c);
        if (p >= key_name[s].len()) begin
          key_state[s] = FLAG_FOUND | FLAG_AWAIT;
          p = 0;
        end
        key_pos[s] = p;
      end
    end
  endfunction

  function automatic fcp_err_t parse_verdict();
    if (raw_len > FCP_MAX_PAYLOAD) return ERR_TOO_LONG;
    if (amp_cnt != 1 || eq_cnt != 2) return ERR_SEP_COUNT;
    if (!(key_state[0] & FLAG_FOUND) || !(key_state[1] & FLAG_FOUND)) return ERR_KEY_MISSING;
    for (int s = 0; s < 2; s++) begin
      if (key_state[s] & (FLAG_AWAIT | FLAG_BAD)) return ERR_NO_EQUALS;
    end
    if (val_len[0] > FCP_MAX_VALUE_CHARS) return ERR_OUTLET_LONG;
    if (val_len[1] > FCP_MAX_VALUE_CHARS) return ERR_DURATION_LONG;
    if ((val_neg[0] && val_acc[0] != 0) || val_acc[0] > OUTLET_MAX) return ERR_OUTLET_RANGE;
    if (val_neg[1] || val_acc[1] == 0 || val_acc[1] > DURATION_MAX) return ERR_DURATION_RANGE;
    return ERR_NONE;
  endfunction

  function automatic void predict_command_result(logic [7:0] b, logic fin, logic eo);
    fcp_err_t    verdict;
    fcp_result_t r;
    if (!eo) begin
      if (raw_len <= FCP_MAX_PAYLOAD) raw_len++;
      if (b != CH_SPACE && b != CH_TAB && b != CH_LF) begin
        if (b == CH_AMP && amp_cnt < 3) amp_cnt++;
        else if (b == CH_EQ && eq_cnt < 3) eq_cnt++;
        if (b == CH_NUL) nul_hit = 1'b1;
        else if (!nul_hit) scan_char(b);
      end
    end
    if (fin || eo) begin
      verdict         = parse_verdict();
      r.accepted      = (verdict == ERR_NONE);
      r.error_code    = verdict;
      r.outlet_number = r.accepted ? val_acc[0][7:0] : 8'd0;
      r.run_seconds   = r.accepted ? val_acc[1][15:0] : 16'd0;
      parse_results_q.push_back(r);
      clear_parse_state();
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    fcp_result_t want;
    if (!rst && result.valid && result.ready) begin
      results_seen++;
      if (parse_results_q.size() == 0) begin
        $error("result with none outstanding: error_code %0d", result.payload.error_code);
        mismatch_count++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(result.payload.accepted));
        check_field("error_code", 32'(want.error_code), 32'(result.payload.error_code));
        check_field("outlet_number", 32'(want.outlet_number),
                    32'(result.payload.outlet_number));
        check_field("run_seconds", 32'(want.run_seconds), 32'(result.payload.run_seconds));
      end
    end
  end

  // entered and left at a falling edge; valid stays high on return
  task automatic send_request(logic [7:0] b, logic fin, logic eo);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.payload <= '{data_byte: b, final_item: fin, end_only: eo};
    do @(posedge clk); while (!cmd.ready);
    predict_command_result(b, fin, eo);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int style);
    int n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_request(msg_bytes[i], (style != STYLE_END_ONLY) && (i == n - 1),
                   (style == STYLE_FINAL_BOTH) && (i == n - 1));
    end
    if (style == STYLE_END_ONLY || n == 0) begin
      send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end
  endtask

  task automatic wait_results_drained();
    cmd.valid <= 1'b0;
    @(negedge clk);
    while (parse_results_q.size() != 0) @(negedge clk);
  endtask

  function automatic void put_text(string t);
    for (int i = 0; i < t.len(); i++) msg_bytes.push_back(t[i]);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  function automatic void put_value(bit outlet);
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(99);
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(2))
          0: msg_bytes.push_back(CH_VT);
          1: msg_bytes.push_back(CH_FF);
          default: msg_bytes.push_back(CH_CR);
        endcase
      end
    end
    if ($urandom_range(5) == 0) msg_bytes.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 12)) msg_bytes.push_back(CH_ZERO);
    if (sel < 70) begin
      v = outlet ? $urandom_range(255) : ($urandom_range(1) ? $urandom_range(1, 300)
                                                             : $urandom_range(1, 65535));
    end else if (sel < 85) begin
      v = outlet ? $urandom_range(256, 1000) : ($urandom_range(3) == 0 ? 0
                                                : $urandom_range(65536, 70000));
    end else if (sel < 95) begin
      v = $urandom;
    end
    if (sel < 95) put_text($sformatf("%0d", v));
    if ($urandom_range(9) == 0) put_text($urandom_range(1) ? "x" : "-7");
  endfunction

  function automatic void build_command();
    int unsigned dur_first;
    int unsigned s;
    dur_first = $urandom_range(1);
    msg_bytes.delete();
    if ($urandom_range(5) == 0) put_text(decoys[$urandom_range(6)]);
    for (int k = 0; k < 2; k++) begin
      if (k != 0) msg_bytes.push_back(CH_AMP);
      s = k ^ dur_first;
      put_text(key_name[s]);
      msg_bytes.push_back(CH_EQ);
      put_value(s == 0);
    end
  endfunction

  function automatic void sprinkle_blanks(int unsigned pct);
    logic [7:0] spread[$];
    foreach (msg_bytes[i]) begin
      while ($urandom_range(99) < pct) spread.push_back(blank_char());
      spread.push_back(msg_bytes[i]);
    end
    msg_bytes = spread;
  endfunction

  function automatic void corrupt_command();
    int unsigned pos;
    repeat ($urandom_range(1, 2)) begin
      pos = $urandom_range(msg_bytes.size() - 1);
      case ($urandom_range(3))
        0: msg_bytes[pos] = 8'($urandom_range(255));
        1: msg_bytes.delete(pos);
        2: msg_bytes.insert(pos, 8'($urandom_range(255)));
        default: begin
          case ($urandom_range(2))
            0: msg_bytes.insert(pos, CH_NUL);
            1: msg_bytes.insert(pos, CH_AMP);
            default: msg_bytes.insert(pos, CH_EQ);
          endcase
        end
      endcase
    end
  endfunction

  function automatic void build_random_message();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      msg_bytes.delete();
      repeat ($urandom_range(0, 30)) msg_bytes.push_back(8'($urandom_range(255)));
    end else begin
      build_command();
      if ($urandom_range(1)) sprinkle_blanks($urandom_range(5, 30));
      if (sel < 30) corrupt_command();
      if ($urandom_range(39) == 0) repeat ($urandom_range(220, 250)) msg_bytes.push_front(blank_char());
    end
  endfunction

  task automatic send_text(string t, int style);
    msg_bytes.delete();
    put_text(t);
    send_message(style);
  endtask

  task automatic test_empty_message();
    msg_bytes.delete();
    send_message(STYLE_END_ONLY);
  endtask

  task automatic test_byte_extremes();
    msg_bytes = '{8'hFF, CH_NUL, 8'h80, 8'h7F, 8'h55, 8'hAA};
    send_message(STYLE_FINAL_BOTH);
    msg_bytes = '{8'hFF, CH_AMP, CH_NUL, CH_EQ};
    send_message(STYLE_FINAL_BYTE);
  endtask

  task automatic test_value_ranges();
    send_text("pumpGpio=255&durationS=65535", STYLE_FINAL_BYTE);
    send_text("durationS=1&pumpGpio=0", STYLE_END_ONLY);
    send_text("pumpGpio=256&durationS=5", STYLE_FINAL_BYTE);
    send_text("pumpGpio=-1&durationS=5", STYLE_FINAL_BYTE);
    send_text("pumpGpio=1&durationS=0", STYLE_FINAL_BOTH);
    send_text("pumpGpio=1&durationS=65536", STYLE_FINAL_BYTE);
    send_text("pumpGpio=1&durationS=-5", STYLE_FINAL_BYTE);
    send_text("pumpGpio=1&durationS=99999999999", STYLE_FINAL_BYTE);
    send_text("pumpGpio=000000000001&durationS=1", STYLE_FINAL_BYTE);
    send_text("pumpGpio=1&durationS=999999999999999", STYLE_FINAL_BYTE);
    send_text("pumpGpio=12abc&durationS=9x", STYLE_FINAL_BYTE);
  endtask

  task automatic test_sign_and_blanks();
    msg_bytes.delete();
    put_text("pump Gpio=");
    msg_bytes.push_back(CH_VT);
    put_text("-0&\tdurationS\n=");
    msg_bytes.push_back(CH_CR);
    msg_bytes.push_back(CH_FF);
    put_text("+30 ");
    send_message(STYLE_FINAL_BYTE);
  endtask

  task automatic test_key_placement();
    send_text("pumpGpio=1&duration=2", STYLE_FINAL_BYTE);
    send_text("pumpGpioX==&durationS", STYLE_FINAL_BYTE);
    send_text("a=1&b=2pumpGpiodurationS", STYLE_END_ONLY);
    send_text("pumpGpumpGpio=3&ddurationS=4", STYLE_FINAL_BYTE);
  endtask

  task automatic test_zero_byte();
    msg_bytes.delete();
    put_text("pumpGpio=5&durationS=7");
    msg_bytes.push_back(CH_NUL);
    put_text("x=&");
    send_message(STYLE_FINAL_BYTE);
    msg_bytes.delete();
    put_text("pumpGpio=5&durationS=7");
    msg_bytes.push_back(CH_NUL);
    put_text("xyz");
    send_message(STYLE_FINAL_BYTE);
  endtask

  task automatic test_length_limits();
    for (int extra = 0; extra < 2; extra++) begin
      msg_bytes.delete();
      put_text("pumpGpio=1&durationS=2");
      while (msg_bytes.size() < FCP_MAX_PAYLOAD + extra) msg_bytes.push_front(CH_SPACE);
      send_message(STYLE_FINAL_BYTE);
    end
  endtask

  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned item_goal, int unsigned result_goal);
    int unsigned first_req;
    int unsigned first_res;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_req = requests_sent;
    first_res = results_seen;
    while (requests_sent - first_req < item_goal || results_seen - first_res < result_goal) begin
      build_random_message();
      send_message($urandom_range(2));
    end
    wait_results_drained();
  endtask

  initial begin
    rst            = 1'b1;
    cmd.valid      = 1'b0;
    cmd.payload    = '0;
    send_idle_pct  = 30;
    recv_idle_pct  = 62;
    requests_sent  = 0;
    results_seen   = 0;
    mismatch_count = 0;
    clear_parse_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_message();
    test_byte_extremes();
    test_value_ranges();
    test_sign_and_blanks();
    test_key_placement();
    test_zero_byte();
    test_length_limits();
    wait_results_drained();

    test_random_traffic(30, 62, 40, 2);
    test_random_traffic(62, 30, 40, 2);
    test_random_traffic(0, 0, 40, 2);

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && parse_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fcp_pkg.sv
hw/rtl/fcp_cmd_if.sv
hw/rtl/fcp_result_if.sv
hw/rtl/fcp_key_match.sv
hw/rtl/fcp_eval.sv
hw/rtl/form_command_parser.sv
hw/rtl/fcp_checker.sv
bench/form_command_parser_test.sv
